// File: hdl/assert_macros.svh
// Shared assertion macros for the packet receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/fpr_pkg.sv
package fpr_pkg;

    // Field widths fixed by the packet format.
    localparam int BYTE_W        = 8;
    localparam int IDX_W         = 6;
    localparam int CFG_IDX_W     = 1;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = 1;
    localparam int QCNT_W        = 2;

    // Start, size, type, checksum and stop bytes around the payload.
    localparam int FRAME_OVERHEAD = 5;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_MARKER  = 1'b1;

    // Input operation codes.
    localparam logic OP_BYTE    = 1'b0;
    localparam logic OP_CONSUME = 1'b1;

    // Result status codes.
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // Classified input beat as it waits in the queue.
    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] data;
        logic              is_start;
        logic              is_stop;
    } t_cmd;

    // Head of the queue as seen by the back end.
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_q_head;

    // Back end sequencer states.
    typedef enum logic [1:0] {
        B_IDLE,
        B_CHECK,
        B_EMIT,
        B_REJECT
    } t_back_state;

endpackage

// File: hdl/fpr_in_if.sv
interface fpr_in_if import fpr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              op;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output op, output rx_byte, input ready);
    modport sink   (input valid, input op, input rx_byte, output ready);
endinterface

// File: hdl/fpr_out_if.sv
interface fpr_out_if import fpr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              status;
    logic [BYTE_W-1:0] pkt_byte;
    logic [IDX_W-1:0]  byte_index;
    logic              last;

    modport source (output valid, output status, output pkt_byte, output byte_index,
                    output last, input ready);
    modport sink   (input valid, input status, input pkt_byte, input byte_index,
                    input last, output ready);
endinterface

// File: hdl/fpr_ram.sv
module fpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 74
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port; read data holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/fpr_front.sv
module fpr_front import fpr_pkg::*; (
    fpr_in_if.sink             i_in,
    input  logic [BYTE_W-1:0]  i_start_marker,
    input  logic [BYTE_W-1:0]  i_stop_marker,
    input  logic               i_full,
    output logic               o_push,
    output t_cmd               o_cmd
);

    // Take a beat whenever the queue has room.
    assign i_in.ready = !i_full;
    assign o_push     = i_in.valid && !i_full;

    // Classify the byte against the framing markers on the way in.
    always_comb begin
        o_cmd.op       = i_in.op;
        o_cmd.data     = i_in.rx_byte;
        o_cmd.is_start = (i_in.rx_byte == i_start_marker);
        o_cmd.is_stop  = (i_in.rx_byte == i_stop_marker);
    end

endmodule

// File: hdl/fpr_queue.sv
`include "assert_macros.svh"

module fpr_queue import fpr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    output logic    o_full,
    input  logic    i_pop,
    output t_q_head o_head
);

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full         = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_head.valid   = (r_count != '0);
    assign o_head.cmd     = r_mem[r_rd_ptr];

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    `ASSERT_RST(a_no_push_when_full, i_clk, i_rst_n, i_push |-> !o_full, "queue push while full")
    `ASSERT_RST(a_no_pop_when_empty, i_clk, i_rst_n, i_pop |-> o_head.valid, "queue pop while empty")

endmodule

// File: hdl/fpr_back.sv
`include "assert_macros.svh"

module fpr_back import fpr_pkg::*; #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [BYTE_W-1:0] i_start_marker,
    input  logic [BYTE_W-1:0] i_stop_marker,
    input  t_q_head           i_head,
    output logic              o_pop,
    fpr_out_if.source         o_out
);

    localparam int PKT_MAX = MAX_PAYLOAD + FRAME_OVERHEAD;
    localparam int CNT_W   = $clog2(PKT_MAX + 1);
    localparam int ADDR_W  = $clog2(2 * PKT_MAX);
    localparam int SUM_W   = BYTE_W + 1;

    t_back_state r_state, n_state;

    // Buffer bookkeeping.
    logic [CNT_W-1:0] r_fill_cnt [2];
    logic [CNT_W-1:0] n_fill_cnt [2];
    logic [1:0]       r_ready, n_ready;
    logic             r_fill_sel, n_fill_sel;
    logic             r_in_pkt, n_in_pkt;

    // Consume walk.
    logic             r_sel, n_sel;
    logic [CNT_W-1:0] r_len, n_len;
    logic [CNT_W-1:0] r_rd_cnt, n_rd_cnt;
    logic             r_pend, n_pend;
    logic [CNT_W-1:0] r_pend_idx, n_pend_idx;
    logic [BYTE_W-1:0] r_xor, n_xor;
    logic             r_bad, n_bad;

    // Output register.
    logic              r_out_vld, n_out_vld;
    logic              r_out_status, n_out_status;
    logic [BYTE_W-1:0] r_pkt_byte, n_pkt_byte;
    logic [IDX_W-1:0]  r_out_idx, n_out_idx;
    logic              r_out_last, n_out_last;

    // Store ports.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [BYTE_W-1:0] ram_wdata;
    logic              rd_issue;
    logic [ADDR_W-1:0] ram_raddr;
    logic [BYTE_W-1:0] ram_rdata;

    // Control terms shared by the sequencer and the datapath.
    logic             out_free;
    logic             rd_more;
    logic             pend_last;
    logic             emit_load;
    logic             rej_load;
    logic             chk_last;
    logic             chk_fail;
    logic             byte_go;
    logic             cons_go;
    logic             cons_idx;
    logic [CNT_W-1:0] cons_len;
    logic             free_now;
    logic [1:0]       ready_after;

    fpr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (2 * PKT_MAX)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (rd_issue),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign out_free  = !r_out_vld || o_out.ready;
    assign rd_more   = (r_rd_cnt != r_len);
    assign pend_last = (r_pend_idx == r_len - CNT_W'(1));
    assign emit_load = (r_state == B_EMIT) && r_pend && out_free;
    assign rej_load  = (r_state == B_REJECT) && out_free;
    assign chk_last  = (r_state == B_CHECK) && r_pend && pend_last;
    assign chk_fail  = r_bad || (ram_rdata != i_stop_marker) || (r_xor != '0);
    assign free_now  = (emit_load && pend_last) || rej_load;

    // Reads run one byte per cycle in the check pass; in the emit pass a read
    // is only issued when the previous byte leaves for the output register.
    assign rd_issue = ((r_state == B_CHECK) && rd_more)
                   || ((r_state == B_EMIT) && rd_more && (!r_pend || emit_load));
    assign ram_raddr = (r_sel ? ADDR_W'(PKT_MAX) : '0) + ADDR_W'(r_rd_cnt);

    assign o_pop    = (r_state == B_IDLE) && i_head.valid;
    assign byte_go  = o_pop && (i_head.cmd.op == OP_BYTE);
    assign cons_go  = o_pop && (i_head.cmd.op == OP_CONSUME) && (|r_ready);
    assign cons_idx = !r_ready[0];
    assign cons_len = r_fill_cnt[cons_idx];

    always_comb begin
        ready_after           = r_ready;
        ready_after[r_sel]    = 1'b0;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE: begin
                if (cons_go) begin
                    n_state = (cons_len < CNT_W'(FRAME_OVERHEAD)) ? B_REJECT : B_CHECK;
                end
            end
            B_CHECK: begin
                if (chk_last) begin
                    n_state = chk_fail ? B_REJECT : B_EMIT;
                end
            end
            B_EMIT: begin
                if (emit_load && pend_last) begin
                    n_state = B_IDLE;
                end
            end
            B_REJECT: begin
                if (rej_load) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    // Datapath and bookkeeping updates.
    always_comb begin
        logic             fill;
        logic             other;
        logic [CNT_W-1:0] cnt_eff;
        logic             do_store;

        n_fill_cnt   = r_fill_cnt;
        n_ready      = r_ready;
        n_fill_sel   = r_fill_sel;
        n_in_pkt     = r_in_pkt;
        n_sel        = r_sel;
        n_len        = r_len;
        n_rd_cnt     = r_rd_cnt;
        n_pend       = r_pend;
        n_pend_idx   = r_pend_idx;
        n_xor        = r_xor;
        n_bad        = r_bad;
        n_out_vld    = r_out_vld && !o_out.ready;
        n_out_status = r_out_status;
        n_pkt_byte   = r_pkt_byte;
        n_out_idx    = r_out_idx;
        n_out_last   = r_out_last;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = i_head.cmd.data;

        fill     = r_fill_sel;
        cnt_eff  = r_fill_cnt[r_fill_sel];
        do_store = 1'b0;

        // Received byte: hunt for start, collect, close on stop.
        if (byte_go) begin
            if (!r_in_pkt) begin
                if (i_head.cmd.is_start && !(r_ready[0] && r_ready[1])) begin
                    fill       = r_ready[r_fill_sel] ? !r_fill_sel : r_fill_sel;
                    n_fill_sel = fill;
                    cnt_eff    = '0;
                    do_store   = 1'b1;
                end
            end else if (cnt_eff >= CNT_W'(PKT_MAX)) begin
                // Overflow abandons the packet.
                n_fill_cnt[fill] = '0;
                n_in_pkt         = 1'b0;
            end else begin
                do_store = 1'b1;
            end
        end
        other = !fill;

        if (do_store) begin
            ram_we           = 1'b1;
            ram_waddr        = (fill ? ADDR_W'(PKT_MAX) : '0) + ADDR_W'(cnt_eff);
            n_fill_cnt[fill] = cnt_eff + CNT_W'(1);
            n_in_pkt         = 1'b1;
            if (i_head.cmd.is_stop) begin
                n_ready[fill] = 1'b1;
                n_in_pkt      = 1'b0;
                if (!r_ready[other]) begin
                    n_fill_sel        = other;
                    n_fill_cnt[other] = '0;
                end
            end
        end

        // Consume request: latch the buffer and clear the check state.
        if (cons_go) begin
            n_sel    = cons_idx;
            n_len    = cons_len;
            n_rd_cnt = '0;
            n_pend   = 1'b0;
            n_xor    = '0;
            n_bad    = 1'b0;
        end

        // Check pass: frame fields and running checksum over size to checksum.
        if (r_state == B_CHECK) begin
            n_pend = rd_issue;
            if (rd_issue) begin
                n_rd_cnt   = r_rd_cnt + CNT_W'(1);
                n_pend_idx = r_rd_cnt;
            end
            if (r_pend) begin
                if (r_pend_idx == '0) begin
                    n_bad = n_bad || (ram_rdata != i_start_marker);
                end
                if (r_pend_idx == CNT_W'(1)) begin
                    n_bad = n_bad || (ram_rdata > BYTE_W'(MAX_PAYLOAD))
                         || ((SUM_W'(ram_rdata) + SUM_W'(FRAME_OVERHEAD)) != SUM_W'(r_len));
                end
                if ((r_pend_idx != '0) && !pend_last) begin
                    n_xor = r_xor ^ ram_rdata;
                end
            end
            if (chk_last) begin
                n_rd_cnt = '0;
                n_pend   = 1'b0;
            end
        end

        // Emit pass: move each byte read into the output register.
        if (r_state == B_EMIT) begin
            n_pend = rd_issue || (r_pend && !emit_load);
            if (rd_issue) begin
                n_rd_cnt   = r_rd_cnt + CNT_W'(1);
                n_pend_idx = r_rd_cnt;
            end
        end

        if (emit_load) begin
            n_out_vld    = 1'b1;
            n_out_status = STATUS_OK;
            n_pkt_byte   = ram_rdata;
            n_out_idx    = IDX_W'(r_pend_idx);
            n_out_last   = pend_last;
        end

        if (rej_load) begin
            n_out_vld    = 1'b1;
            n_out_status = STATUS_REJECT;
            n_pkt_byte   = '0;
            n_out_idx    = '0;
            n_out_last   = 1'b1;
        end

        // Free the consumed buffer and repoint filling if it is stuck on a full one.
        if (free_now) begin
            n_fill_cnt[r_sel] = '0;
            n_ready[r_sel]    = 1'b0;
            if (!r_in_pkt && ready_after[r_fill_sel]) begin
                n_fill_sel = r_sel;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= B_IDLE;
            r_fill_cnt[0] <= '0;
            r_fill_cnt[1] <= '0;
            r_ready       <= '0;
            r_fill_sel    <= 1'b0;
            r_in_pkt      <= 1'b0;
            r_rd_cnt      <= '0;
            r_pend        <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill_cnt <= n_fill_cnt;
            r_ready    <= n_ready;
            r_fill_sel <= n_fill_sel;
            r_in_pkt   <= n_in_pkt;
            r_rd_cnt   <= n_rd_cnt;
            r_pend     <= n_pend;
            r_out_vld  <= n_out_vld;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_sel        <= n_sel;
        r_len        <= n_len;
        r_pend_idx   <= n_pend_idx;
        r_xor        <= n_xor;
        r_bad        <= n_bad;
        r_out_status <= n_out_status;
        r_pkt_byte   <= n_pkt_byte;
        r_out_idx    <= n_out_idx;
        r_out_last   <= n_out_last;
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.status     = r_out_status;
    assign o_out.pkt_byte   = r_pkt_byte;
    assign o_out.byte_index = r_out_idx;
    assign o_out.last       = r_out_last;

    `ASSERT_RST(a_no_store_while_busy, i_clk, i_rst_n, (r_state != B_IDLE) |-> !ram_we, "store written during a consume walk")
    `ASSERT_RST(a_fill_not_ready, i_clk, i_rst_n, r_in_pkt |-> !r_ready[r_fill_sel], "filling a buffer that is already ready")
    `ASSERT_RST(a_emit_in_range, i_clk, i_rst_n, emit_load |-> ((r_pend_idx < r_len) && (r_len >= CNT_W'(FRAME_OVERHEAD))), "emitted byte outside the packet")
    `ASSERT_RST(a_free_clears, i_clk, i_rst_n, free_now |=> (r_state == B_IDLE) && !r_ready[r_sel], "consumed buffer not freed")

endmodule

// File: hdl/framed_packet_receiver_double_buffer.sv
// Channel   Dir   Beat contents                         Handshake
// i_in      in    op, rx_byte                           valid / ready
// o_out     out   status, pkt_byte, byte_index, last    valid / ready
// i_cfg_*   in    register index, write data            write enable only
//
// A received byte passes the two-entry queue before the back end takes it.
// A consume request walks the chosen buffer twice through the store's single read port:
// a check pass over the whole frame, then one output beat per cycle while the sink is ready.
// A packet that fails the check, or is too short to check, yields a single reject beat.
// Reset is synchronous and active low; the store itself is not cleared.
// The two-entry queue lets the front keep queueing beats while a result waits, until it fills.
module framed_packet_receiver_double_buffer import fpr_pkg::*; #(
    parameter int MAX_PAYLOAD = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    fpr_in_if.sink               i_in,
    fpr_out_if.source            o_out,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_data
);

    logic [BYTE_W-1:0] r_start_marker;
    logic [BYTE_W-1:0] r_stop_marker;

    logic    q_push;
    logic    q_full;
    logic    q_pop;
    t_cmd    q_cmd;
    t_q_head q_head;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= 8'd2;
            r_stop_marker  <= 8'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START_MARKER: r_start_marker <= i_cfg_data;
                CFG_STOP_MARKER:  r_stop_marker  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    fpr_front u_front (
        .i_in           (i_in),
        .i_start_marker (r_start_marker),
        .i_stop_marker  (r_stop_marker),
        .i_full         (q_full),
        .o_push         (q_push),
        .o_cmd          (q_cmd)
    );

    fpr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_head  (q_head)
    );

    fpr_back #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start_marker (r_start_marker),
        .i_stop_marker  (r_stop_marker),
        .i_head         (q_head),
        .o_pop          (q_pop),
        .o_out          (o_out)
    );

endmodule

// File: sim/tb_framed_packet_receiver_double_buffer.sv
`timescale 1ns / 100ps

module tb_framed_packet_receiver_double_buffer;
    import fpr_pkg::*;

    localparam int MAX_PL         = 32;
    localparam int PKT_LEN        = MAX_PL + FRAME_OVERHEAD;
    localparam int IDLE_PCT       = 31;
    localparam int HOLD_CYCLES    = 250;
    localparam int SETTLE_CYCLES  = 50;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 55;

    // One result beat as the block presents it.
    typedef struct packed {
        logic              status;
        logic [BYTE_W-1:0] data;
        logic [IDX_W-1:0]  idx;
        logic              last;
    } t_result_beat;

    // How a directed row is checked.
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NONE,
        CHK_TYPED
    } t_chk;

    typedef struct packed {
        logic              op;
        logic [BYTE_W-1:0] data;
        t_chk              chk;
        t_result_beat      want;
    } t_stim_row;

    typedef enum logic [1:0] {
        PK_GOOD,
        PK_BAD_SUM,
        PK_BAD_SIZE,
        PK_OVERFLOW
    } t_pkt_kind;

    localparam t_result_beat NO_BEAT     = '0;
    localparam t_result_beat REJECT_BEAT = '{status: STATUS_REJECT, data: 8'h00,
                                             idx: 6'd0, last: 1'b1};

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_idx;
    logic [BYTE_W-1:0]    cfg_data;

    fpr_in_if  rx_chan ();
    fpr_out_if res_chan ();

    framed_packet_receiver_double_buffer #(
        .MAX_PAYLOAD(MAX_PL)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in       (rx_chan),
        .o_out      (res_chan),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Predictor state: two packet buffers and the framing state.
    logic [BYTE_W-1:0] buf_bytes [2][PKT_LEN];
    int unsigned       buf_len   [2];
    bit                buf_full  [2];
    bit                wr_buf;
    bit                framing;
    logic [BYTE_W-1:0] mk_start;
    logic [BYTE_W-1:0] mk_stop;

    t_result_beat due_beats[$];
    t_result_beat consume_beats[$];

    int  err_cnt;
    int  n_in_beats;
    int  n_consumes;
    int  n_out_beats;
    int  n_rejects;
    int  n_settings;
    bit  no_idle;
    bit  hold_req;
    int  hold_left;
    int  quiet_cycles;

    // Directed stimulus at the reset markers (start 0x02, stop 0x03).
    t_stim_row directed_rows [24] = '{
        '{OP_CONSUME, 8'h00, CHK_NONE,  NO_BEAT},     // nothing ready yet
        '{OP_BYTE,    8'h00, CHK_MODEL, NO_BEAT},     // noise while hunting
        '{OP_BYTE,    8'hFF, CHK_MODEL, NO_BEAT},
        '{OP_BYTE,    8'h02, CHK_MODEL, NO_BEAT},     // empty payload, type equals start
        '{OP_BYTE,    8'h00, CHK_MODEL, NO_BEAT},
        '{OP_BYTE,    8'h02, CHK_MODEL, NO_BEAT},
        '{OP_BYTE,    8'h02, CHK_MODEL, NO_BEAT},
        '{OP_BYTE,    8'h03, CHK_MODEL, NO_BEAT},
        '{OP_CONSUME, 8'hFF, CHK_MODEL, NO_BEAT},
        '{OP_BYTE,    8'h02, CHK_MODEL, NO_BEAT},     // wrong checksum
        '{OP_BYTE,    8'h00, CHK_MODEL, NO_BEAT},
        '{OP_BYTE,    8'hFF, CHK_MODEL, NO_BEAT},
        '{OP_BYTE,    8'hFE, CHK_MODEL, NO_BEAT},
        '{OP_BYTE,    8'h03, CHK_MODEL, NO_BEAT},
        '{OP_CONSUME, 8'h00, CHK_TYPED, REJECT_BEAT},
        '{OP_BYTE,    8'h02, CHK_MODEL, NO_BEAT},     // two short frames fill both buffers
        '{OP_BYTE,    8'h03, CHK_MODEL, NO_BEAT},
        '{OP_BYTE,    8'h02, CHK_MODEL, NO_BEAT},
        '{OP_BYTE,    8'h03, CHK_MODEL, NO_BEAT},
        '{OP_BYTE,    8'h02, CHK_MODEL, NO_BEAT},     // start dropped, both buffers busy
        '{OP_BYTE,    8'h03, CHK_MODEL, NO_BEAT},
        '{OP_CONSUME, 8'h00, CHK_TYPED, REJECT_BEAT},
        '{OP_CONSUME, 8'h00, CHK_TYPED, REJECT_BEAT},
        '{OP_CONSUME, 8'h00, CHK_NONE,  NO_BEAT}
    };

    // Full frame check of one buffer holding len bytes.
    function automatic bit frame_is_valid(bit b, int unsigned len);
        logic [BYTE_W-1:0] size;
        logic [BYTE_W-1:0] sum;
        if (len < FRAME_OVERHEAD || len > PKT_LEN) return 1'b0;
        if (buf_bytes[b][0] != mk_start) return 1'b0;
        size = buf_bytes[b][1];
        if (size > MAX_PL) return 1'b0;
        if (len != size + FRAME_OVERHEAD) return 1'b0;
        if (buf_bytes[b][4 + size] != mk_stop) return 1'b0;
        sum = buf_bytes[b][1] ^ buf_bytes[b][2];
        for (int i = 0; i < size; i++) begin
            sum ^= buf_bytes[b][3 + i];
        end
        return sum == buf_bytes[b][3 + size];
    endfunction

    // A received byte: hunt for start, collect, close on stop.
    function automatic void rx_take_byte(logic [BYTE_W-1:0] b);
        bit fill;
        bit oth;
        fill = wr_buf;
        oth  = ~fill;
        if (!framing) begin
            if (b != mk_start) return;
            if (buf_full[fill]) begin
                if (buf_full[oth]) return;
                wr_buf = oth;
                fill   = oth;
            end
            buf_len[fill] = 0;
            framing = 1'b1;
        end
        fill = wr_buf;
        // A byte beyond the buffer abandons the packet.
        if (buf_len[fill] >= PKT_LEN) begin
            buf_len[fill] = 0;
            framing = 1'b0;
            return;
        end
        buf_bytes[fill][buf_len[fill]] = b;
        buf_len[fill]++;
        if (b == mk_stop) begin
            buf_full[fill] = 1'b1;
            framing = 1'b0;
            oth = ~fill;
            if (!buf_full[oth]) begin
                wr_buf = oth;
                buf_len[oth] = 0;
            end
        end
    endfunction

    // A consume request: emit or reject the ready buffer, then free it.
    function automatic void rx_consume();
        bit           sel;
        int unsigned  len;
        t_result_beat bt;
        consume_beats.delete();
        if (buf_full[0]) sel = 1'b0;
        else if (buf_full[1]) sel = 1'b1;
        else return;
        len = buf_len[sel];
        if (frame_is_valid(sel, len)) begin
            for (int i = 0; i < len; i++) begin
                bt.status = STATUS_OK;
                bt.data   = buf_bytes[sel][i];
                bt.idx    = 6'(i);
                bt.last   = (i == len - 1);
                consume_beats.push_back(bt);
            end
        end else begin
            consume_beats.push_back(REJECT_BEAT);
        end
        buf_len[sel]  = 0;
        buf_full[sel] = 1'b0;
        // Point filling at the freed buffer if the current one is still full.
        if (!framing && buf_full[wr_buf]) wr_buf = sel;
    endfunction

    function automatic logic [BYTE_W-1:0] byte_except(logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == v);
        return b;
    endfunction

    // Mostly short payloads, now and then long or full size.
    function automatic int pick_size();
        int r;
        r = $urandom_range(0, 99);
        if (r < 85) return $urandom_range(0, 6);
        if (r < 95) return $urandom_range(7, MAX_PL - 1);
        return MAX_PL;
    endfunction

    // Offer one input beat, with random gaps, and predict it once accepted.
    task automatic send_beat(logic op, logic [BYTE_W-1:0] data,
                             t_chk chk = CHK_MODEL, t_result_beat want = NO_BEAT);
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
            rx_chan.valid <= 1'b0;
            @(negedge clk);
        end
        rx_chan.valid   <= 1'b1;
        rx_chan.op      <= op;
        rx_chan.rx_byte <= data;
        do @(posedge clk); while (!rx_chan.ready);
        n_in_beats++;
        if (op == OP_BYTE) begin
            rx_take_byte(data);
        end else begin
            n_consumes++;
            rx_consume();
            case (chk)
                CHK_MODEL: begin
                    foreach (consume_beats[k]) due_beats.push_back(consume_beats[k]);
                end
                CHK_TYPED: begin
                    due_beats.push_back(want);
                end
                default: ;
            endcase
        end
    endtask

    // One frame with random content; the kind decides how it is broken.
    task automatic send_packet(t_pkt_kind kind);
        int                n;
        logic [BYTE_W-1:0] size;
        logic [BYTE_W-1:0] typ;
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] sum;
        send_beat(OP_BYTE, mk_start);
        if (kind == PK_OVERFLOW) begin
            repeat (PKT_LEN + 3) send_beat(OP_BYTE, byte_except(mk_stop));
            return;
        end
        n    = pick_size();
        size = (kind == PK_BAD_SIZE) ? 8'($urandom_range(0, 255)) : 8'(n);
        typ  = byte_except(mk_stop);
        sum  = size ^ typ;
        send_beat(OP_BYTE, size);
        send_beat(OP_BYTE, typ);
        repeat (n) begin
            b = byte_except(mk_stop);
            sum ^= b;
            send_beat(OP_BYTE, b);
        end
        if (kind == PK_BAD_SUM) sum ^= 8'(1 << $urandom_range(0, 7));
        send_beat(OP_BYTE, sum);
        send_beat(OP_BYTE, mk_stop);
    endtask

    // Mostly well-formed frames, mixed with broken ones, noise and consumes.
    task automatic random_phase(int target);
        int first;
        int r;
        first = n_in_beats;
        while (n_in_beats - first < target) begin
            r = $urandom_range(0, 99);
            if (r < 60) send_packet(PK_GOOD);
            else if (r < 68) send_packet(PK_BAD_SUM);
            else if (r < 75) send_packet(PK_BAD_SIZE);
            else if (r < 78) send_packet(PK_OVERFLOW);
            else if (r < 88) send_beat(OP_BYTE, 8'($urandom_range(0, 255)));
            else send_beat(OP_CONSUME, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 99) < 55) send_beat(OP_CONSUME, 8'($urandom_range(0, 255)));
        end
    endtask

    // Drop valid, wait for all results, then let the queue and back end drain.
    task automatic settle();
        @(negedge clk);
        rx_chan.valid <= 1'b0;
        while (due_beats.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_marker(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] val);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge clk);
        if (idx == CFG_START_MARKER) mk_start = val;
        else mk_stop = val;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_markers(logic [BYTE_W-1:0] start_val, logic [BYTE_W-1:0] stop_val);
        write_marker(CFG_START_MARKER, start_val);
        write_marker(CFG_STOP_MARKER, stop_val);
        n_settings++;
    endtask

    // Compare each accepted result beat with the oldest expectation.
    task automatic check_beat();
        t_result_beat got;
        t_result_beat want;
        got.status = res_chan.status;
        got.data   = res_chan.pkt_byte;
        got.idx    = res_chan.byte_index;
        got.last   = res_chan.last;
        n_out_beats++;
        if (got.status == STATUS_REJECT) n_rejects++;
        if (due_beats.size() == 0) begin
            $display("%0t: unexpected result beat status=%0d byte=%02h index=%0d last=%0d",
                     $time, got.status, got.data, got.idx, got.last);
            err_cnt++;
            return;
        end
        want = due_beats.pop_front();
        if (got.status !== want.status || got.data !== want.data ||
            got.idx !== want.idx || got.last !== want.last) begin
            $display("%0t: result mismatch: expected status=%0d byte=%02h index=%0d last=%0d,",
                     $time, want.status, want.data, want.idx, want.last);
            $display("%0t:                  actual   status=%0d byte=%02h index=%0d last=%0d",
                     $time, got.status, got.data, got.idx, got.last);
            err_cnt++;
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && res_chan.valid && res_chan.ready) check_beat();
    end

    // Result side: random stalls, plus one long hold-off on request.
    initial begin
        res_chan.ready = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_req) begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_chan.ready <= 1'b0;
            end else begin
                res_chan.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // Watchdog on cycles with no beat moving on either channel.
    always @(posedge clk) begin
        if ((rx_chan.valid && rx_chan.ready) || (res_chan.valid && res_chan.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [BYTE_W-1:0] rnd_start;
        rst_n            = 1'b0;
        cfg_we           = 1'b0;
        cfg_idx          = '0;
        cfg_data         = '0;
        rx_chan.valid    = 1'b0;
        rx_chan.op       = OP_BYTE;
        rx_chan.rx_byte  = '0;
        quiet_cycles     = 0;
        err_cnt          = 0;
        n_in_beats       = 0;
        n_consumes       = 0;
        n_out_beats      = 0;
        n_rejects        = 0;
        n_settings       = 1;
        no_idle          = 1'b0;
        hold_req         = 1'b0;
        buf_len[0]       = 0;
        buf_len[1]       = 0;
        buf_full[0]      = 1'b0;
        buf_full[1]      = 1'b0;
        wr_buf           = 1'b0;
        framing          = 1'b0;
        mk_start         = 8'h02;
        mk_stop          = 8'h03;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows at the reset markers.
        foreach (directed_rows[i]) begin
            send_beat(directed_rows[i].op, directed_rows[i].data,
                      directed_rows[i].chk, directed_rows[i].want);
        end
        random_phase(PHASE_ITEMS);

        // Long hold-off on the result side while frames keep coming in.
        hold_req = 1'b1;
        repeat (3) begin
            send_packet(PK_GOOD);
            send_beat(OP_CONSUME, 8'h00);
        end
        settle();

        // Extreme markers, with no idling on either side.
        set_markers(8'h00, 8'hFF);
        no_idle = 1'b1;
        random_phase(PHASE_ITEMS);
        settle();
        no_idle = 1'b0;

        set_markers(8'hFF, 8'h00);
        random_phase(PHASE_ITEMS);
        settle();

        set_markers(8'h7E, 8'h7D);
        random_phase(PHASE_ITEMS);
        settle();

        rnd_start = 8'($urandom_range(0, 255));
        set_markers(rnd_start, byte_except(rnd_start));
        random_phase(PHASE_ITEMS);
        settle();

        $display("Covered %0d input beats (%0d consume requests) over %0d marker settings,",
                 n_in_beats, n_consumes, n_settings);
        $display("and %0d result beats (%0d rejects) including a long result-side stall.",
                 n_out_beats, n_rejects);
        if (err_cnt == 0 && due_beats.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
